// File: rtl/core/blit_rop_pkg.sv
// shared types and constants for the rgb565 raster operation pixel unit
`timescale 1ns / 1ps
`default_nettype none
package blit_rop_pkg;

  localparam int unsigned PIXEL_W = 16;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned INDEX_W = 1;
  localparam int unsigned DATA_W  = 16;

  typedef logic [PIXEL_W-1:0] pixel_t;

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_ROP_MODE   = 1'd0;
  localparam logic [INDEX_W-1:0] REG_KEY_COLOUR = 1'd1;

  typedef enum logic [MODE_W-1:0] {
    ROP_COPY     = 4'd0,
    ROP_TRANSP   = 4'd1,
    ROP_GRAY     = 4'd2,
    ROP_REVERSE  = 4'd3,
    ROP_OR       = 4'd4,
    ROP_XOR      = 4'd5,
    ROP_NOT      = 4'd6,
    ROP_MERGENOT = 4'd7,
    ROP_ANDNOT   = 4'd8,
    ROP_AND      = 4'd9
  } rop_mode_t;

  typedef struct packed {
    logic [MODE_W-1:0] rop_mode;
    pixel_t            key_colour;
  } rop_cfg_t;

  // luma = (60 r + 118 g + 22 b) / 25, the divide folded into the weights
  // as a multiply by ceil(2^17 / 25) and a shift; exact for sums up to 6200
  localparam int unsigned LUMA_W         = 25;
  localparam int unsigned LUMA_DIV_MUL   = 5243;
  localparam int unsigned LUMA_DIV_SHIFT = 17;
  localparam logic [LUMA_W-1:0] LUMA_R_K = LUMA_W'(60 * LUMA_DIV_MUL);
  localparam logic [LUMA_W-1:0] LUMA_G_K = LUMA_W'(118 * LUMA_DIV_MUL);
  localparam logic [LUMA_W-1:0] LUMA_B_K = LUMA_W'(22 * LUMA_DIV_MUL);

endpackage
`default_nettype wire

// File: rtl/core/blit_rop_cfg.sv
// configuration registers: raster mode and transparent key colour
`timescale 1ns / 1ps
`default_nettype none
module blit_rop_cfg (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [blit_rop_pkg::INDEX_W-1:0]  cfg_index,
  input  wire [blit_rop_pkg::DATA_W-1:0]   cfg_data,
  output blit_rop_pkg::rop_cfg_t           cfg
);
  import blit_rop_pkg::*;

  logic [MODE_W-1:0] rop_mode;
  pixel_t            key_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      rop_mode   <= '0;
      key_colour <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROP_MODE:   rop_mode   <= cfg_data[MODE_W-1:0];
        REG_KEY_COLOUR: key_colour <= cfg_data[PIXEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.rop_mode   = rop_mode;
  assign cfg.key_colour = key_colour;

endmodule
`default_nettype wire

// File: rtl/core/blit_rop_alu.sv
// per-pixel combine logic: ten raster operations, key test and gray conversion
`timescale 1ns / 1ps
`default_nettype none
module blit_rop_alu (
  input  wire blit_rop_pkg::rop_cfg_t cfg,
  input  wire blit_rop_pkg::pixel_t   src,
  input  wire blit_rop_pkg::pixel_t   dst,
  output blit_rop_pkg::pixel_t        pixel,
  output logic                        we
);
  import blit_rop_pkg::*;

  logic              keyed;
  logic [4:0]        red;
  logic [4:0]        green;
  logic [4:0]        blue;
  logic [LUMA_W-1:0] luma_acc;
  logic [7:0]        luma;
  pixel_t            gray;

  assign keyed = (src == cfg.key_colour);

  // green takes the top five of its six bits
  assign red   = src[15:11];
  assign green = src[10:6];
  assign blue  = src[4:0];

  assign luma_acc = LUMA_W'(red) * LUMA_R_K + LUMA_W'(green) * LUMA_G_K
                  + LUMA_W'(blue) * LUMA_B_K;
  assign luma     = luma_acc[LUMA_DIV_SHIFT +: 8];
  assign gray     = {luma[7:3], luma[7:2], luma[7:3]};

  always_comb begin
    pixel = dst;
    we    = 1'b1;
    case (rop_mode_t'(cfg.rop_mode))
      ROP_COPY:     pixel = src;
      ROP_TRANSP:   if (keyed) we = 1'b0; else pixel = src;
      ROP_GRAY:     if (keyed) we = 1'b0; else pixel = gray;
      ROP_REVERSE:  if (keyed) we = 1'b0; else pixel = ~src;
      ROP_OR:       pixel = src | dst;
      ROP_XOR:      pixel = src ^ dst;
      ROP_NOT:      pixel = ~src;
      ROP_MERGENOT: pixel = ~src | dst;
      ROP_ANDNOT:   pixel = ~src & dst;
      ROP_AND:      pixel = src & dst;
      default:      we = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/blit_raster_op_pixel_unit_top.sv
// top level of the rgb565 raster operation pixel unit
//
//  channel  | signals                               | transfer when
//  ---------+---------------------------------------+---------------------------
//  input    | in_valid, in_stall, src_pixel,        | in_valid && !in_stall
//           | dst_pixel                             |
//  output   | out_valid, out_stall, out_pixel,      | out_valid && !out_stall
//           | write_enable                          |
//  config   | cfg_we, cfg_index, cfg_data           | cfg_we
//
// one pixel per cycle sustained while the output is not stalled; a pixel
// passes the input register, then the result register holding the combine,
// before its output transfer
// synchronous reset empties both stages and clears mode and key to zero
// output stall holds the result register; the input stage takes pixels while
// it is empty or the result register is free or being drained
`timescale 1ns / 1ps
`default_nettype none
module blit_raster_op_pixel_unit_top (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire [15:0]                       src_pixel,
  input  wire [15:0]                       dst_pixel,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [15:0]                      out_pixel,
  output logic                             write_enable,
  input  wire                              cfg_we,
  input  wire [blit_rop_pkg::INDEX_W-1:0]  cfg_index,
  input  wire [blit_rop_pkg::DATA_W-1:0]   cfg_data
);
  import blit_rop_pkg::*;

  rop_cfg_t cfg;
  logic     in_full;
  pixel_t   src_q;
  pixel_t   dst_q;
  pixel_t   alu_pixel;
  logic     alu_we;
  logic     res_load;
  logic     in_load;

  blit_rop_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  blit_rop_alu u_alu (
    .cfg   (cfg),
    .src   (src_q),
    .dst   (dst_q),
    .pixel (alu_pixel),
    .we    (alu_we)
  );

  // result register takes a new value when empty or being drained
  assign res_load = !out_valid || !out_stall;
  assign in_stall = in_full && !res_load;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_load) begin
      in_full <= 1'b1;
    end else if (res_load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      src_q <= src_pixel;
      dst_q <= dst_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load && in_full) begin
      out_pixel    <= alu_pixel;
      write_enable <= alu_we;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/blit_rop_checker.sv
// port-level checks for the raster operation pixel unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module blit_rop_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [15:0] out_pixel,
  input wire        write_enable
);

  // the input side only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // every input transfer is followed by out_valid, after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> ##2 out_valid)
    else $error("accepted pixel gave no result in time");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(out_pixel) && $stable(write_enable)))
    else $error("stalled result changed");

endmodule

bind blit_raster_op_pixel_unit_top blit_rop_checker u_blit_rop_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_pixel    (out_pixel),
  .write_enable (write_enable)
);
`default_nettype wire
